/* rtl/block_mapped_flash_translation_macros.svh */
// Assertion macros shared by the flash translation RTL.
// Each macro expands to one labeled concurrent assertion clocked on clk and gated by rst_n.
`ifndef BLOCK_MAPPED_FLASH_TRANSLATION_MACROS_SVH
`define BLOCK_MAPPED_FLASH_TRANSLATION_MACROS_SVH

// Same-cycle implication.
`define BMFT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define BMFT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/bmft_pkg.sv */
// Package for the block-mapped flash translation block: field widths,
// parameter defaults, command codes and status codes. No dependencies.
`default_nettype none

package bmft_pkg;

    localparam int PAGES_IN_BLOCK_DEF   = 32;
    localparam int DATA_BLOCK_COUNT_DEF = 64;

    localparam int OP_W       = 1;
    localparam int SECTOR_W   = 11;
    localparam int COMMAND_W  = 3;
    localparam int PAGE_OUT_W = 12;
    localparam int ERASE_W    = 7;
    localparam int STATUS_W   = 1;

    typedef enum logic [OP_W-1:0] {
        OP_READ  = 1'b0,
        OP_WRITE = 1'b1
    } op_t;

    typedef enum logic [COMMAND_W-1:0] {
        CMD_NONE  = 3'd0,
        CMD_READ  = 3'd1,
        CMD_WRITE = 3'd2,
        CMD_COPY  = 3'd3,
        CMD_ERASE = 3'd4
    } command_t;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 1'b0;
    localparam logic [STATUS_W-1:0] STATUS_NO_DATA = 1'b1;

endpackage

`default_nettype wire

/* rtl/bmft_if.sv */
// Valid/ready channels of the flash translation block: request in, flash command out.
// Depends on bmft_pkg for field widths.
`default_nettype none

interface bmft_req_if
    import bmft_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     operation;
    logic [SECTOR_W-1:0] logical_sector;

    modport source (output valid, output operation, output logical_sector, input ready);
    modport sink   (input valid, input operation, input logical_sector, output ready);
endinterface

interface bmft_cmd_if
    import bmft_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [COMMAND_W-1:0]  command;
    logic [PAGE_OUT_W-1:0] target_page;
    logic [PAGE_OUT_W-1:0] source_page;
    logic [ERASE_W-1:0]    erase_block;
    logic [STATUS_W-1:0]   status;
    logic                  last;

    modport source (
        output valid, output command, output target_page, output source_page,
        output erase_block, output status, output last, input ready
    );
    modport sink (
        input valid, input command, input target_page, input source_page,
        input erase_block, input status, input last, output ready
    );
endinterface

`default_nettype wire

/* rtl/block_mapped_flash_translation.sv */
// Block-mapped flash translation: sector requests in, flash page commands out.
// Reset: async, active low; then a clearing pass over the flag memories (no request taken).
// Sequence: a read or first write has its single beat registered after the reciprocal multiply,
//   table lookup, block pick, and block base with page-flag read; the next request waits for it.
//   Out-of-range rejects follow the lookup, unmapped reads the block pick. A stalled output holds them.
// Overwrite: copies into the spare, new page write, erase beat; one copy beat per cycle unless stalled.
`default_nettype none

`include "block_mapped_flash_translation_macros.svh"

module block_mapped_flash_translation
    import bmft_pkg::*;
#(
    parameter int PAGES_IN_BLOCK   = PAGES_IN_BLOCK_DEF,
    parameter int DATA_BLOCK_COUNT = DATA_BLOCK_COUNT_DEF
)(
    input  logic       clk,
    input  logic       rst_n,
    bmft_req_if.sink   request,
    bmft_cmd_if.source flash
);

    // ------------------------------------------------------------------
    // Derived widths
    // ------------------------------------------------------------------
    localparam int OFF_W  = $clog2(PAGES_IN_BLOCK);             // page offset in a block
    localparam int BLK_W  = $clog2(DATA_BLOCK_COUNT + 1);       // physical block, spare incl.
    localparam int IDX_W  = (DATA_BLOCK_COUNT > 1) ? $clog2(DATA_BLOCK_COUNT) : 1;
    localparam int PAGE_W = $clog2((DATA_BLOCK_COUNT + 1) * PAGES_IN_BLOCK);

    // Reciprocal of PAGES_IN_BLOCK: ceil(2^RECIP_SH / pages). The error term stays
    // below 2^RECIP_SH over the whole sector range, so quotient and remainder are exact.
    localparam int RECIP_SH = SECTOR_W + OFF_W;
    localparam int RECIP    = ((1 << RECIP_SH) + PAGES_IN_BLOCK - 1) / PAGES_IN_BLOCK;
    localparam int RECIP_W  = SECTOR_W + 1;
    localparam int PROD_W   = SECTOR_W + RECIP_W;
    localparam int REM_W    = RECIP_SH + OFF_W + 1;

    // ------------------------------------------------------------------
    // Sequencer states
    // ------------------------------------------------------------------
    typedef enum logic [10:0] {
        S_CLEAR = 11'b000_0000_0001,   // post-reset sweep of the flag memories
        S_IDLE  = 11'b000_0000_0010,   // ready for a request
        S_DIV   = 11'b000_0000_0100,   // reciprocal multiply: block number and fraction
        S_LOOK  = 11'b000_0000_1000,   // range check, read map tables, page offset
        S_DEC   = 11'b000_0001_0000,   // pick physical block
        S_PBASE = 11'b000_0010_0000,   // pbn * pages, read page-written row
        S_ACT   = 11'b000_0100_0000,   // read / plain write, or start overwrite
        S_SBASE = 11'b000_1000_0000,   // spare * pages
        S_COPY  = 11'b001_0000_0000,   // copy the other pages into the spare
        S_WRITE = 11'b010_0000_0000,   // new page into the spare
        S_ERASE = 11'b100_0000_0000    // erase old block, swap it in as spare
    } state_t;

    state_t state_reg, state_next;

    // ------------------------------------------------------------------
    // Working registers
    // ------------------------------------------------------------------
    logic                      op_reg, op_next;
    logic [SECTOR_W-1:0]       work_reg, work_next;    // sector, then logical block
    logic [OFF_W-1:0]          rem_reg, rem_next;      // page offset
    logic [RECIP_SH-1:0]       frac_reg, frac_next;    // fraction of sector / pages
    logic [BLK_W-1:0]          pbn_reg, pbn_next;
    logic [BLK_W-1:0]          spare_reg, spare_next;
    logic [BLK_W-1:0]          clr_reg, clr_next;
    logic [PAGE_W-1:0]         pbase_reg, pbase_next;
    logic [PAGE_W-1:0]         sbase_reg, sbase_next;
    logic [OFF_W-1:0]          idx_reg, idx_next;      // copy index
    logic [PAGES_IN_BLOCK-1:0] pwsave_reg, pwsave_next;

    // ------------------------------------------------------------------
    // Memories: mapped flag and map per logical block, page-written per
    // physical block. Read data registered.
    // ------------------------------------------------------------------
    logic                      mapped_mem [DATA_BLOCK_COUNT];
    logic [BLK_W-1:0]          map_mem    [DATA_BLOCK_COUNT];
    logic [PAGES_IN_BLOCK-1:0] pw_mem     [DATA_BLOCK_COUNT + 1];

    logic                      mapped_rd_reg;
    logic [BLK_W-1:0]          map_rd_reg;
    logic [PAGES_IN_BLOCK-1:0] pw_rd_reg;

    logic                      tab_re;
    logic                      mapped_we;
    logic [IDX_W-1:0]          mapped_wa;
    logic                      mapped_wd;
    logic                      map_we;
    logic [BLK_W-1:0]          map_wd;
    logic                      pw_re;
    logic                      pw_we;
    logic [BLK_W-1:0]          pw_wa;
    logic [PAGES_IN_BLOCK-1:0] pw_wd;

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic                  out_valid_reg, out_valid_next;
    command_t              cmd_reg;
    logic [PAGE_OUT_W-1:0] tgt_reg;
    logic [PAGE_OUT_W-1:0] src_reg;
    logic [ERASE_W-1:0]    ers_reg;
    logic [STATUS_W-1:0]   st_reg;
    logic                  last_reg;

    logic                  out_free;
    logic                  out_load;
    logic                  emit;
    command_t              emit_cmd;
    logic [PAGE_W-1:0]     emit_tgt;
    logic [PAGE_W-1:0]     emit_src;
    logic [BLK_W-1:0]      emit_ers;
    logic [STATUS_W-1:0]   emit_st;
    logic                  emit_last;

    // ------------------------------------------------------------------
    // Shared datapath pieces
    // ------------------------------------------------------------------
    logic [PROD_W-1:0]         recip_prod;
    logic [REM_W-1:0]          rem_prod;
    logic                      in_range;
    logic [IDX_W-1:0]          lbn_idx;
    logic [BLK_W-1:0]          mul_in;
    logic [PAGE_W-1:0]         mul_out;
    logic [PAGES_IN_BLOCK-1:0] page_bit;

    // Sector / PAGES_IN_BLOCK by constant multiply: integer part is the block,
    // the fraction times the page count gives the offset on the next cycle.
    assign recip_prod = PROD_W'(work_reg) * PROD_W'(RECIP);
    assign rem_prod   = REM_W'(frac_reg) * REM_W'(PAGES_IN_BLOCK);

    assign in_range = (work_reg < SECTOR_W'(DATA_BLOCK_COUNT));
    assign lbn_idx  = IDX_W'(work_reg);
    assign page_bit = PAGES_IN_BLOCK'(1) << rem_reg;

    // Shared multiplier: block number to first page, used for both bases.
    assign mul_in  = (state_reg == S_SBASE) ? spare_reg : pbn_reg;
    assign mul_out = PAGE_W'(mul_in) * PAGE_W'(PAGES_IN_BLOCK);

    assign out_free = !out_valid_reg || flash.ready;
    assign out_load = emit && out_free;

    assign request.ready = (state_reg == S_IDLE);

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        work_next   = work_reg;
        rem_next    = rem_reg;
        frac_next   = frac_reg;
        pbn_next    = pbn_reg;
        spare_next  = spare_reg;
        clr_next    = clr_reg;
        pbase_next  = pbase_reg;
        sbase_next  = sbase_reg;
        idx_next    = idx_reg;
        pwsave_next = pwsave_reg;

        emit      = 1'b0;
        emit_cmd  = CMD_NONE;
        emit_tgt  = '0;
        emit_src  = '0;
        emit_ers  = '0;
        emit_st   = STATUS_OK;
        emit_last = 1'b0;

        tab_re    = 1'b0;
        mapped_we = 1'b0;
        mapped_wa = lbn_idx;
        mapped_wd = 1'b1;
        map_we    = 1'b0;
        map_wd    = BLK_W'(work_reg);
        pw_re     = 1'b0;
        pw_we     = 1'b0;
        pw_wa     = pbn_reg;
        pw_wd     = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                mapped_we = (clr_reg < BLK_W'(DATA_BLOCK_COUNT));
                mapped_wa = IDX_W'(clr_reg);
                mapped_wd = 1'b0;
                pw_we     = 1'b1;
                pw_wa     = clr_reg;
                if (clr_reg == BLK_W'(DATA_BLOCK_COUNT))
                    state_next = S_IDLE;
                else
                    clr_next = clr_reg + BLK_W'(1);
            end

            S_IDLE:
            begin
                if (request.valid)
                begin
                    op_next    = request.operation;
                    work_next  = request.logical_sector;
                    state_next = S_DIV;
                end
            end

            S_DIV:
            begin
                work_next  = SECTOR_W'(recip_prod >> RECIP_SH);
                frac_next  = recip_prod[RECIP_SH-1:0];
                state_next = S_LOOK;
            end

            S_LOOK:
            begin
                if (!in_range)
                begin
                    emit      = 1'b1;
                    emit_st   = STATUS_NO_DATA;
                    emit_last = 1'b1;
                    if (out_free)
                        state_next = S_IDLE;
                end
                else
                begin
                    rem_next   = rem_prod[RECIP_SH +: OFF_W];
                    tab_re     = 1'b1;
                    state_next = S_DEC;
                end
            end

            S_DEC:
            begin
                if (op_reg == OP_READ && !mapped_rd_reg)
                begin
                    emit      = 1'b1;
                    emit_st   = STATUS_NO_DATA;
                    emit_last = 1'b1;
                    if (out_free)
                        state_next = S_IDLE;
                end
                else
                begin
                    // first write lands on the physical block of the same number
                    pbn_next   = mapped_rd_reg ? map_rd_reg : BLK_W'(work_reg);
                    state_next = S_PBASE;
                end
            end

            S_PBASE:
            begin
                pbase_next = mul_out;
                pw_re      = 1'b1;
                state_next = S_ACT;
            end

            S_ACT:
            begin
                if (op_reg == OP_READ)
                begin
                    emit      = 1'b1;
                    emit_cmd  = CMD_READ;
                    emit_tgt  = pbase_reg + PAGE_W'(rem_reg);
                    emit_last = 1'b1;
                    if (out_free)
                        state_next = S_IDLE;
                end
                else if (!mapped_rd_reg || !pw_rd_reg[rem_reg])
                begin
                    emit      = 1'b1;
                    emit_cmd  = CMD_WRITE;
                    emit_tgt  = pbase_reg + PAGE_W'(rem_reg);
                    emit_last = 1'b1;
                    pw_we     = out_free;
                    pw_wd     = pw_rd_reg | page_bit;
                    mapped_we = out_free && !mapped_rd_reg;
                    map_we    = out_free && !mapped_rd_reg;
                    if (out_free)
                        state_next = S_IDLE;
                end
                else
                begin
                    pwsave_next = pw_rd_reg;
                    state_next  = S_SBASE;
                end
            end

            S_SBASE:
            begin
                sbase_next = mul_out;
                idx_next   = '0;
                state_next = S_COPY;
            end

            S_COPY:
            begin
                // the page being overwritten is skipped without a beat
                emit     = (idx_reg != rem_reg);
                emit_cmd = CMD_COPY;
                emit_tgt = sbase_reg + PAGE_W'(idx_reg);
                emit_src = pbase_reg + PAGE_W'(idx_reg);
                if (idx_reg == rem_reg || out_free)
                begin
                    if (idx_reg == OFF_W'(PAGES_IN_BLOCK - 1))
                        state_next = S_WRITE;
                    else
                        idx_next = idx_reg + OFF_W'(1);
                end
            end

            S_WRITE:
            begin
                emit     = 1'b1;
                emit_cmd = CMD_WRITE;
                emit_tgt = sbase_reg + PAGE_W'(rem_reg);
                pw_we    = out_free;
                pw_wa    = spare_reg;
                pw_wd    = pwsave_reg | page_bit;
                if (out_free)
                    state_next = S_ERASE;
            end

            S_ERASE:
            begin
                emit      = 1'b1;
                emit_cmd  = CMD_ERASE;
                emit_ers  = pbn_reg;
                emit_last = 1'b1;
                pw_we     = out_free;
                pw_wa     = pbn_reg;
                pw_wd     = '0;
                map_we    = out_free;
                map_wd    = spare_reg;
                if (out_free)
                begin
                    spare_next = pbn_reg;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    assign out_valid_next = out_load ? 1'b1 : (flash.ready ? 1'b0 : out_valid_reg);

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            spare_reg     <= BLK_W'(DATA_BLOCK_COUNT);
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            spare_reg     <= spare_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        work_reg   <= work_next;
        rem_reg    <= rem_next;
        frac_reg   <= frac_next;
        pbn_reg    <= pbn_next;
        pbase_reg  <= pbase_next;
        sbase_reg  <= sbase_next;
        pwsave_reg <= pwsave_next;
        if (out_load)
        begin
            cmd_reg  <= emit_cmd;
            tgt_reg  <= PAGE_OUT_W'(emit_tgt);
            src_reg  <= PAGE_OUT_W'(emit_src);
            ers_reg  <= ERASE_W'(emit_ers);
            st_reg   <= emit_st;
            last_reg <= emit_last;
        end
    end

    // ------------------------------------------------------------------
    // Memories
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (mapped_we)
            mapped_mem[mapped_wa] <= mapped_wd;
        if (map_we)
            map_mem[lbn_idx] <= map_wd;
        if (tab_re)
        begin
            mapped_rd_reg <= mapped_mem[lbn_idx];
            map_rd_reg    <= map_mem[lbn_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pw_we)
            pw_mem[pw_wa] <= pw_wd;
        if (pw_re)
            pw_rd_reg <= pw_mem[pbn_reg];
    end

    // ------------------------------------------------------------------
    // Outputs
    // ------------------------------------------------------------------
    assign flash.valid       = out_valid_reg;
    assign flash.command     = cmd_reg;
    assign flash.target_page = tgt_reg;
    assign flash.source_page = src_reg;
    assign flash.erase_block = ers_reg;
    assign flash.status      = st_reg;
    assign flash.last        = last_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `BMFT_ASSERT_NOW(a_nodata_is_none, flash.valid && flash.status == STATUS_NO_DATA, flash.command == CMD_NONE, "no-data beat carries a command")
    `BMFT_ASSERT_NOW(a_accept_after_last, request.valid && request.ready, !(out_valid_reg && !last_reg), "request taken mid-sequence")
    `BMFT_ASSERT_NOW(a_copy_distinct, state_reg == S_COPY, spare_reg != pbn_reg, "copy into the source block")
    `BMFT_ASSERT_NXT(a_spare_swap, state_reg == S_ERASE && out_load, spare_reg == $past(pbn_reg), "spare not swapped after erase")

endmodule

`default_nettype wire
